// ----- rtl/core/tsg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOUR_BITS = 16;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int CNT_BITS    = COORD_BITS + 3;

    // Upper bound on Bresenham steps for one row walk.
    localparam logic [CNT_BITS-1:0] WALK_CAP = {1'b1, {(CNT_BITS - 1){1'b0}}};

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOUR_BITS-1:0]     colour_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [CNT_BITS-1:0]        cnt_t;

    typedef struct packed {
        logic    operation;
        coord_t  x_first;
        coord_t  y_first;
        coord_t  x_second;
        coord_t  y_second;
        coord_t  x_third;
        coord_t  y_third;
        colour_t fill_colour;
    } tsg_in_t;

    typedef struct packed {
        coord_t  span_x_short;
        coord_t  span_x_long;
        coord_t  span_row;
        colour_t span_colour;
        logic    span_valid;
        logic    span_last;
    } tsg_out_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } vertex_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        err_t   err;
        coord_t dx;
        coord_t dy;
        logic   step_x;
    } walker_t;

    typedef struct packed {
        logic load_sorted;
        logic setup_lower;
        logic setup_upper;
        logic latch_row;
        logic walk_step;
        logic down;
        logic out_load;
        logic out_zero;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic row_is_mid;
        logic low_lt_mid;
        logic mid_lt_top;
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_LOWER = 3'b010,
        PH_UPPER = 3'b100
    } phase_t;

    function automatic walker_t edge_setup(vertex_t from_v, vertex_t to_v);
        walker_t w;
        coord_t  dx;
        coord_t  dy;
        dx = (from_v.x < to_v.x) ? (to_v.x - from_v.x) : (from_v.x - to_v.x);
        dy = (from_v.y < to_v.y) ? (to_v.y - from_v.y) : (from_v.y - to_v.y);
        w.x      = from_v.x;
        w.y      = from_v.y;
        w.err    = $signed({{(ERR_BITS - COORD_BITS){1'b0}}, dx})
                 - $signed({{(ERR_BITS - COORD_BITS){1'b0}}, dy});
        w.dx     = dx;
        w.dy     = dy;
        w.step_x = (from_v.x < to_v.x) ? 1'b0 : 1'b1;
        return w;
    endfunction

    // One Bresenham step; both tests use the error value from before the step.
    function automatic walker_t edge_step(walker_t w, logic down);
        walker_t                   r;
        logic signed [ERR_BITS:0]  e2;
        logic signed [ERR_BITS:0]  dxs;
        logic signed [ERR_BITS:0]  dys;
        logic signed [ERR_BITS:0]  acc;
        r   = w;
        e2  = {w.err, 1'b0};
        dxs = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, w.dx});
        dys = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, w.dy});
        acc = {w.err[ERR_BITS-1], w.err};
        if (e2 > -dys) begin
            acc = acc - dys;
            r.x = w.step_x ? (w.x - COORD_BITS'(1)) : (w.x + COORD_BITS'(1));
        end
        if (e2 < dxs) begin
            acc = acc + dxs;
            r.y = down ? (w.y - COORD_BITS'(1)) : (w.y + COORD_BITS'(1));
        end
        r.err = acc[ERR_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tsg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsg_datapath (
    input  wire logic              aclk,
    input  wire tsg_pkg::tsg_in_t  s_data,
    input  wire tsg_pkg::cmd_t     cmd,
    output tsg_pkg::sts_t          sts,
    output tsg_pkg::tsg_out_t      m_data
);

    tsg_pkg::vertex_t  sorted_reg [3];
    tsg_pkg::colour_t  colour_reg;
    tsg_pkg::walker_t  short_reg;
    tsg_pkg::walker_t  long_reg;
    tsg_pkg::coord_t   row_reg;
    tsg_pkg::cnt_t     cnt_reg;
    tsg_pkg::tsg_out_t out_reg;

    tsg_pkg::vertex_t  v0, v1, v2, vt;
    logic              short_act;
    logic              long_act;

    // Stable three-element sort by y: on a tie the earlier vertex stays lower.
    always_comb begin
        vt = '0;
        v0 = '{y: s_data.y_first,  x: s_data.x_first};
        v1 = '{y: s_data.y_second, x: s_data.x_second};
        v2 = '{y: s_data.y_third,  x: s_data.x_third};
        if (v0.y > v1.y) begin
            vt = v0; v0 = v1; v1 = vt;
        end
        if (v1.y > v2.y) begin
            vt = v1; v1 = v2; v2 = vt;
        end
        if (v0.y > v1.y) begin
            vt = v0; v0 = v1; v1 = vt;
        end
    end

    assign short_act = (short_reg.y != row_reg) && (cnt_reg != tsg_pkg::WALK_CAP);
    assign long_act  = (long_reg.y != row_reg) && (cnt_reg != tsg_pkg::WALK_CAP);

    always_ff @(posedge aclk) begin
        if (cmd.load_sorted) begin
            sorted_reg[0] <= v0;
            sorted_reg[1] <= v1;
            sorted_reg[2] <= v2;
            colour_reg    <= s_data.fill_colour;
        end

        if (cmd.setup_lower) begin
            short_reg <= tsg_pkg::edge_setup(sorted_reg[0], sorted_reg[1]);
            long_reg  <= tsg_pkg::edge_setup(sorted_reg[0], sorted_reg[2]);
        end else if (cmd.setup_upper) begin
            short_reg <= tsg_pkg::edge_setup(sorted_reg[2], sorted_reg[1]);
            long_reg  <= tsg_pkg::edge_setup(sorted_reg[2], sorted_reg[0]);
        end else if (cmd.walk_step) begin
            if (short_act) begin
                short_reg <= tsg_pkg::edge_step(short_reg, cmd.down);
            end
            if (long_act) begin
                long_reg <= tsg_pkg::edge_step(long_reg, cmd.down);
            end
        end

        if (cmd.latch_row) begin
            row_reg <= cmd.down ? (short_reg.y - tsg_pkg::COORD_BITS'(1))
                                : (short_reg.y + tsg_pkg::COORD_BITS'(1));
            cnt_reg <= '0;
        end else if (cmd.walk_step && (short_act || long_act)) begin
            cnt_reg <= cnt_reg + tsg_pkg::CNT_BITS'(1);
        end

        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                out_reg <= '0;
            end else begin
                out_reg.span_x_short <= short_reg.x;
                out_reg.span_x_long  <= long_reg.x;
                out_reg.span_row     <= row_reg;
                out_reg.span_colour  <= colour_reg;
                out_reg.span_valid   <= 1'b1;
                out_reg.span_last    <= cmd.out_last;
            end
        end
    end

    assign sts.walk_done  = !short_act && !long_act;
    assign sts.row_is_mid = (row_reg == sorted_reg[1].y);
    assign sts.low_lt_mid = (sorted_reg[0].y < sorted_reg[1].y);
    assign sts.mid_lt_top = (sorted_reg[1].y < sorted_reg[2].y);

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tsg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsg_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire tsg_pkg::sts_t  sts,
    output tsg_pkg::cmd_t       cmd
);

    tsg_pkg::state_t state_reg, state_next;
    tsg_pkg::phase_t phase_reg, phase_next;
    logic            zero_reg, zero_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsg_pkg::ST_IDLE;
            phase_reg   <= tsg_pkg::PH_IDLE;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.down     = (phase_reg == tsg_pkg::PH_UPPER);
        s_ready      = 1'b0;

        unique case (state_reg)
            tsg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == tsg_pkg::OP_START) begin
                        cmd.load_sorted = 1'b1;
                        state_next      = tsg_pkg::ST_SETUP;
                    end else if (phase_reg == tsg_pkg::PH_IDLE) begin
                        zero_next  = 1'b1;
                        state_next = tsg_pkg::ST_EMIT;
                    end else begin
                        zero_next     = 1'b0;
                        cmd.latch_row = 1'b1;
                        state_next    = tsg_pkg::ST_WALK;
                    end
                end
            end
            tsg_pkg::ST_SETUP: begin
                // A flat lower half goes straight to the upper half.
                if (sts.low_lt_mid) begin
                    cmd.setup_lower = 1'b1;
                    phase_next      = tsg_pkg::PH_LOWER;
                end else if (sts.mid_lt_top) begin
                    cmd.setup_upper = 1'b1;
                    phase_next      = tsg_pkg::PH_UPPER;
                end else begin
                    phase_next = tsg_pkg::PH_IDLE;
                end
                state_next = tsg_pkg::ST_IDLE;
            end
            tsg_pkg::ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    state_next = tsg_pkg::ST_EMIT;
                end
            end
            tsg_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = zero_reg;
                    m_valid_next = 1'b1;
                    state_next   = tsg_pkg::ST_IDLE;
                    if (!zero_reg && sts.row_is_mid) begin
                        if (phase_reg == tsg_pkg::PH_LOWER && sts.mid_lt_top) begin
                            cmd.setup_upper = 1'b1;
                            phase_next      = tsg_pkg::PH_UPPER;
                        end else begin
                            cmd.out_last = 1'b1;
                            phase_next   = tsg_pkg::PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = tsg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/triangle_span_generator_top.sv -----
// Filled-triangle span generator with two Bresenham edge walkers.
// Input channel (s_valid/s_ready/s_data): an item with operation start loads
// three vertices and a colour and returns no result; an item with operation
// advance returns exactly one span on the result channel (m_valid/m_ready/
// m_data). An advance with no active triangle returns an all-zero span.
// The final span of a triangle carries span_last.
// Sequencing: a start is accepted in idle, then edge setup runs in the setup
// state. An advance is accepted in idle, where the target row is latched;
// the walkers then step in the walk state until both reach that row, and the
// span is loaded into the output register in the emit state. Both walkers
// step in parallel, one step a cycle.
// One item is in work at a time; s_ready is high only while the controller
// is idle. The output register lets a new item be accepted while the previous
// span still waits; if the receiver stalls, the next span waits in the
// controller until the output register is free, and input is held off.
// Reset (synchronous, aresetn low) returns the block to idle with no triangle
// active and no span pending.
`timescale 1ns / 1ps
`default_nettype none

module triangle_span_generator_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tsg_pkg::tsg_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tsg_pkg::tsg_out_t      m_data
);

    tsg_pkg::cmd_t cmd;
    tsg_pkg::sts_t sts;

    tsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.operation),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsg_datapath u_datapath (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

    // Only one item is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    // An empty span never carries the last marker or a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.span_valid |-> !m_data.span_last && (m_data.span_row == '0))
        else $error("empty span with nonzero fields");

    // A start never produces a result in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation == tsg_pkg::OP_START) && !m_valid
        |=> !m_valid)
        else $error("start transaction produced a span");

    // The walk never runs into the step cap on real geometry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> (u_datapath.cnt_reg != tsg_pkg::WALK_CAP) || sts.walk_done)
        else $error("edge walk hit the step cap");

endmodule

`default_nettype wire

// ----- test/tb_triangle_span_generator_top.sv -----
`timescale 1ns / 1ps

module tb_triangle_span_generator_top;

    import tsg_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 20000000;
    localparam int WALK_LIMIT   = 1 << (COORD_BITS + 2);

    typedef struct {
        coord_t x;
        coord_t y;
        int     err;
        int     dx;
        int     dy;
        bit     x_down;
    } edge_state_t;

    typedef struct {
        tsg_in_t  item;
        bit       typed;
        tsg_out_t span;
    } stim_row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tsg_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tsg_out_t m_data;

    // Span predictor state.
    phase_t      tri_phase;
    edge_state_t short_edge;
    edge_state_t long_edge;
    vertex_t     corners[3];
    colour_t     tri_colour;

    tsg_out_t pending_spans[$];
    int       items_sent;
    int       spans_checked;
    int       error_count;
    int       cycle_count;

    triangle_span_generator_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic edge_state_t edge_start(vertex_t from_v, vertex_t to_v);
        edge_state_t e;
        e.x      = from_v.x;
        e.y      = from_v.y;
        e.dx     = (from_v.x < to_v.x) ? int'(to_v.x) - int'(from_v.x)
                                       : int'(from_v.x) - int'(to_v.x);
        e.dy     = (from_v.y < to_v.y) ? int'(to_v.y) - int'(from_v.y)
                                       : int'(from_v.y) - int'(to_v.y);
        e.err    = e.dx - e.dy;
        e.x_down = !(from_v.x < to_v.x);
        return e;
    endfunction

    // Runs Bresenham steps until the walker's y reaches the requested row.
    function automatic edge_state_t edge_walk_to(edge_state_t e, bit down, coord_t row);
        int e2;
        int n;
        n = 0;
        while (n < WALK_LIMIT && e.y != row) begin
            e2 = e.err * 2;
            if (e2 > -e.dy) begin
                e.err = e.err - e.dy;
                e.x   = e.x_down ? e.x - 1'b1 : e.x + 1'b1;
            end
            if (e2 < e.dx) begin
                e.err = e.err + e.dx;
                e.y   = down ? e.y - 1'b1 : e.y + 1'b1;
            end
            n++;
        end
        return e;
    endfunction

    function automatic void begin_lower_half();
        short_edge = edge_start(corners[0], corners[1]);
        long_edge  = edge_start(corners[0], corners[2]);
        tri_phase  = PH_LOWER;
    endfunction

    function automatic void begin_upper_half();
        short_edge = edge_start(corners[2], corners[1]);
        long_edge  = edge_start(corners[2], corners[0]);
        tri_phase  = PH_UPPER;
    endfunction

    task automatic predict_span(input tsg_in_t item, output bit emits, output tsg_out_t span);
        vertex_t v[3];
        vertex_t t;
        bit      down;
        coord_t  row;
        span  = '0;
        emits = 1'b0;
        if (item.operation == OP_START) begin
            v[0] = {item.y_first, item.x_first};
            v[1] = {item.y_second, item.x_second};
            v[2] = {item.y_third, item.x_third};
            // Stable sort by y: equal rows keep their input order.
            if (v[0].y > v[1].y) begin
                t = v[0]; v[0] = v[1]; v[1] = t;
            end
            if (v[1].y > v[2].y) begin
                t = v[1]; v[1] = v[2]; v[2] = t;
            end
            if (v[0].y > v[1].y) begin
                t = v[0]; v[0] = v[1]; v[1] = t;
            end
            corners    = v;
            tri_colour = item.fill_colour;
            if (v[0].y < v[1].y) begin
                begin_lower_half();
            end else if (v[1].y < v[2].y) begin
                begin_upper_half();
            end else begin
                tri_phase = PH_IDLE;
            end
            return;
        end
        emits = 1'b1;
        if (tri_phase == PH_IDLE) begin
            return;
        end
        down       = (tri_phase == PH_UPPER);
        row        = down ? short_edge.y - 1'b1 : short_edge.y + 1'b1;
        short_edge = edge_walk_to(short_edge, down, row);
        long_edge  = edge_walk_to(long_edge, down, row);
        span.span_x_short = short_edge.x;
        span.span_x_long  = long_edge.x;
        span.span_row     = row;
        span.span_colour  = tri_colour;
        span.span_valid   = 1'b1;
        if (row == corners[1].y) begin
            if (!down && corners[1].y != corners[2].y) begin
                begin_upper_half();
            end else begin
                span.span_last = 1'b1;
                tri_phase      = PH_IDLE;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input tsg_in_t item, input bit typed, input tsg_out_t typed_span);
        int       gap;
        bit       emits;
        tsg_out_t span;
        gap = (items_sent % 100 >= 50 && items_sent % 100 < 70) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        predict_span(item, emits, span);
        if (emits) begin
            pending_spans.push_back(typed ? typed_span : span);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic tsg_in_t random_item();
        tsg_in_t item;
        item.operation   = 1'($urandom);
        item.x_first     = coord_t'($urandom);
        item.y_first     = coord_t'($urandom);
        item.x_second    = coord_t'($urandom);
        item.y_second    = coord_t'($urandom);
        item.x_third     = coord_t'($urandom);
        item.y_third     = coord_t'($urandom);
        item.fill_colour = colour_t'($urandom);
        return item;
    endfunction

    function automatic tsg_in_t start_item(int x1, int y1, int x2, int y2, int x3, int y3,
                                           int colour);
        tsg_in_t item;
        item.operation   = OP_START;
        item.x_first     = coord_t'(x1);
        item.y_first     = coord_t'(y1);
        item.x_second    = coord_t'(x2);
        item.y_second    = coord_t'(y2);
        item.x_third     = coord_t'(x3);
        item.y_third     = coord_t'(y3);
        item.fill_colour = colour_t'(colour);
        return item;
    endfunction

    function automatic tsg_in_t advance_item();
        tsg_in_t item;
        item           = random_item();
        item.operation = OP_ADVANCE;
        return item;
    endfunction

    function automatic coord_t pick_coord(int base, int box);
        return coord_t'(base + $urandom_range(0, box - 1));
    endfunction

    // One start followed by a run of advances, or now and then a lone random item.
    task automatic play_triangle();
        tsg_in_t item;
        int      pick;
        int      box;
        int      x_base;
        int      y_base;
        int      lo_y;
        int      hi_y;
        int      advances;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            send_item(random_item(), 1'b0, '0);
            return;
        end
        box    = (pick < 30) ? 4 : (pick < 58) ? 16 : (pick < 86) ? 64 :
                 (pick < 95) ? 512 : 4096;
        x_base = $urandom_range(0, 4096 - box);
        y_base = $urandom_range(0, 4096 - box);
        item   = random_item();
        item.operation = OP_START;
        item.x_first   = pick_coord(x_base, box);
        item.y_first   = pick_coord(y_base, box);
        item.x_second  = pick_coord(x_base, box);
        item.y_second  = pick_coord(y_base, box);
        item.x_third   = pick_coord(x_base, box);
        item.y_third   = pick_coord(y_base, box);
        lo_y = item.y_first;
        hi_y = item.y_first;
        if (item.y_second < lo_y) lo_y = item.y_second;
        if (item.y_second > hi_y) hi_y = item.y_second;
        if (item.y_third < lo_y) lo_y = item.y_third;
        if (item.y_third > hi_y) hi_y = item.y_third;
        // Wide triangles take up to a full line of steps per row, so keep them short.
        if (box >= 512) begin
            advances = $urandom_range(1, 4);
        end else if ($urandom_range(0, 9) < 7) begin
            advances = hi_y - lo_y + $urandom_range(0, 2);
        end else begin
            advances = $urandom_range(0, hi_y - lo_y);
        end
        send_item(item, 1'b0, '0);
        repeat (advances) send_item(advance_item(), 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result checker: every span transaction is matched to the oldest prediction.
    always @(posedge aclk) begin
        tsg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            spans_checked++;
            if (pending_spans.size() == 0) begin
                if (error_count < 10) begin
                    $display("unexpected span %h/%h/%h/%h/%b/%b", m_data.span_x_short,
                             m_data.span_x_long, m_data.span_row, m_data.span_colour,
                             m_data.span_valid, m_data.span_last);
                end
                error_count++;
            end else begin
                want = pending_spans.pop_front();
                if (m_data.span_x_short !== want.span_x_short ||
                    m_data.span_x_long  !== want.span_x_long  ||
                    m_data.span_row     !== want.span_row     ||
                    m_data.span_colour  !== want.span_colour  ||
                    m_data.span_valid   !== want.span_valid   ||
                    m_data.span_last    !== want.span_last) begin
                    if (error_count < 10) begin
                        $display("span %0d mismatch: expected %h/%h/%h/%h/%b/%b got %h/%h/%h/%h/%b/%b",
                                 spans_checked, want.span_x_short, want.span_x_long,
                                 want.span_row, want.span_colour, want.span_valid,
                                 want.span_last, m_data.span_x_short, m_data.span_x_long,
                                 m_data.span_row, m_data.span_colour, m_data.span_valid,
                                 m_data.span_last);
                    end
                    error_count++;
                end
            end
        end
    end

    // Span receiver with random back-pressure and one long hold-off.
    initial begin
        int gap;
        bit held_off;
        held_off = 1'b0;
        m_ready  = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!held_off && spans_checked >= 120) begin
                held_off = 1'b1;
                gap      = 400;
            end else if (spans_checked % 80 >= 40 && spans_checked % 80 < 60) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 7);
            end
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        stim_row_t directed_rows[$];
        bit        paused;
        tsg_out_t  idle_span;
        idle_span     = '0;
        paused        = 1'b0;
        items_sent    = 0;
        spans_checked = 0;
        error_count   = 0;
        cycle_count   = 0;
        tri_phase     = PH_IDLE;
        short_edge    = '{default: 0};
        long_edge     = '{default: 0};
        tri_colour    = '0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;

        // Advance with no triangle loaded returns an all-zero span.
        directed_rows.push_back('{advance_item(), 1'b1, idle_span});
        // Extreme corners, flat lower half: goes straight to the upper half.
        directed_rows.push_back('{start_item(0, 0, 4095, 0, 0, 4095, 16'hFFFF), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b1,
                                  {12'd1, 12'd0, 12'd4094, 16'hFFFF, 1'b1, 1'b0}});
        directed_rows.push_back('{advance_item(), 1'b0, '0});
        // All three vertices on one row: nothing to draw.
        directed_rows.push_back('{start_item(5, 7, 4000, 7, 100, 7, 16'h1234), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b1, idle_span});
        // Flat upper half with a very shallow long edge; its only span is the last.
        directed_rows.push_back('{start_item(4095, 4095, 0, 4095, 4095, 4094, 16'h0000),
                                  1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b1, idle_span});
        // Both halves; the middle row comes out twice.
        directed_rows.push_back('{start_item(10, 10, 13, 12, 8, 13, 16'hAAAA), 1'b0, '0});
        repeat (3) directed_rows.push_back('{advance_item(), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b1, idle_span});
        // Two vertices on the lowest row: the earlier one sorts lower.
        directed_rows.push_back('{start_item(2, 5, 9, 5, 4, 8, 16'h5555), 1'b0, '0});
        repeat (3) directed_rows.push_back('{advance_item(), 1'b0, '0});
        // A new start drops the triangle in progress.
        directed_rows.push_back('{start_item(4095, 4095, 0, 0, 2048, 4095, 16'h8001),
                                  1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b0, '0});
        directed_rows.push_back('{start_item(1, 1, 3, 1, 2, 2, 16'h7FFE), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b0, '0});
        directed_rows.push_back('{advance_item(), 1'b1, idle_span});

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].span);
        end

        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            // Once, let the block drain completely before sending more.
            if (!paused && items_sent >= 320) begin
                paused  = 1'b1;
                s_valid = 1'b0;
                while (pending_spans.size() != 0) @(negedge aclk);
            end
            play_triangle();
        end
        s_valid = 1'b0;

        while (pending_spans.size() != 0) @(negedge aclk);
        repeat (64) @(negedge aclk);

        if (error_count == 0 && pending_spans.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tsg_pkg.sv
rtl/core/tsg_datapath.sv
rtl/core/tsg_ctrl.sv
rtl/core/triangle_span_generator_top.sv
test/tb_triangle_span_generator_top.sv
